// File: design/rdsgd_pkg.sv
// rdsgd_pkg: shared types, codes and helpers of the rds group decoder
// used by the front, queue, back and top-level modules; no dependencies

package rdsgd_pkg;

    // group type codes taken from the second block
    localparam logic [3:0] GRP_BASIC = 4'd0;
    localparam logic [3:0] GRP_TEXT  = 4'd2;

    // write target codes on the result word
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_PS   = 2'd1;
    localparam logic [1:0] TGT_RT   = 2'd2;

    // characters that radiotext remaps
    localparam logic [6:0] CHR_CR    = 7'h0D;
    localparam logic [6:0] CHR_LF    = 7'h0A;
    localparam logic [6:0] CHR_NUL   = 7'h00;
    localparam logic [6:0] CHR_SPACE = 7'h20;

    localparam int IN_W  = 64;
    localparam int OUT_W = 48;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PS,
        KIND_RT_A,
        KIND_RT_B
    } cmd_kind_t;

    // one decoded group waiting for the back end
    typedef struct packed {
        logic [15:0] prog_id;
        logic [4:0]  prog_type;
        logic        traffic_program;
        logic        traffic_announce;
        logic        music_speech;
        logic [3:0]  decoder_info;
        cmd_kind_t   kind;
        logic [3:0]  segment;
        logic [15:0] block_c;
        logic [15:0] block_d;
    } cmd_t;

    function automatic logic [6:0] conv_text(input logic [7:0] raw);
        logic [6:0] c;
        c = raw[6:0];
        if (c == CHR_CR)
            return CHR_NUL;
        else if (c == CHR_LF)
            return CHR_SPACE;
        else
            return c;
    endfunction

endpackage

// File: design/rdsgd_front.sv
// rdsgd_front: accepts rds groups, classifies them and keeps the TA, MS and DI state
// depends on rdsgd_pkg

module rdsgd_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [15:0]           block_a,
    input  logic [15:0]           block_b,
    input  logic [15:0]           block_c,
    input  logic [15:0]           block_d,
    input  logic                  q_full,
    output logic                  q_push,
    output rdsgd_pkg::cmd_t       q_cmd
);

    logic       announce_reg, announce_next;
    logic       speech_reg, speech_next;
    logic [3:0] info_reg, info_next;

    logic [3:0] group;
    logic       is_basic;
    logic       accept;
    logic [1:0] ps_seg;

    assign group    = block_b[15:12];
    assign is_basic = (group == rdsgd_pkg::GRP_BASIC);
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;
    assign ps_seg   = block_b[1:0];

    always_comb
    begin
        announce_next = announce_reg;
        speech_next   = speech_reg;
        info_next     = info_reg;
        if (accept && is_basic)
        begin
            announce_next = block_b[4];
            speech_next   = block_b[3];
            info_next     = (info_reg & ~(4'b0001 << ps_seg)) | ({3'b000, block_b[2]} << ps_seg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            announce_reg <= 1'b0;
            speech_reg   <= 1'b0;
            info_reg     <= 4'b0000;
        end
        else
        begin
            announce_reg <= announce_next;
            speech_reg   <= speech_next;
            info_reg     <= info_next;
        end
    end

    // the command carries the state as it stands after this group
    always_comb
    begin
        q_cmd.prog_id          = block_a;
        q_cmd.prog_type        = block_b[9:5];
        q_cmd.traffic_program  = block_b[10];
        q_cmd.traffic_announce = announce_next;
        q_cmd.music_speech     = speech_next;
        q_cmd.decoder_info     = info_next;
        q_cmd.segment          = block_b[3:0];
        q_cmd.block_c          = block_c;
        q_cmd.block_d          = block_d;
        case (group)
            rdsgd_pkg::GRP_BASIC: q_cmd.kind = rdsgd_pkg::KIND_PS;
            rdsgd_pkg::GRP_TEXT:  q_cmd.kind = block_b[11] ? rdsgd_pkg::KIND_RT_B
                                                            : rdsgd_pkg::KIND_RT_A;
            default:              q_cmd.kind = rdsgd_pkg::KIND_NONE;
        endcase
    end

endmodule

// File: design/rdsgd_queue.sv
// rdsgd_queue: small first-in first-out queue of decoded group commands
// depends on rdsgd_pkg

module rdsgd_queue #(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rdsgd_pkg::cmd_t   push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output rdsgd_pkg::cmd_t   pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rdsgd_pkg::cmd_t        mem [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: design/rdsgd_back.sv
// rdsgd_back: walks each queued command and emits its character words
// depends on rdsgd_pkg; holds the registered output stage of the top level

module rdsgd_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  rdsgd_pkg::cmd_t       q_cmd,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [15:0]           prog_id,
    output logic [4:0]            prog_type,
    output logic                  traffic_program,
    output logic                  traffic_announce,
    output logic                  music_speech,
    output logic [3:0]            decoder_info,
    output logic [1:0]            write_target,
    output logic [5:0]            char_position,
    output logic [6:0]            char_value,
    output logic                  last
);

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [15:0] prog_id_reg;
    logic [4:0]  prog_type_reg;
    logic        tp_reg, ta_reg, ms_reg;
    logic [3:0]  di_reg;
    logic [1:0]  target_reg;
    logic [5:0]  pos_reg;
    logic [6:0]  char_reg;
    logic        last_reg;

    logic        load;
    logic [1:0]  r_target;
    logic [5:0]  r_pos;
    logic [6:0]  r_char;
    logic        r_last;
    logic [7:0]  d_byte;
    logic [7:0]  rt_byte;

    assign load  = q_valid && (!valid_reg || out_ready);
    assign q_pop = load && r_last;

    // station name and version b text take the two bytes of block d
    assign d_byte = idx_reg[0] ? q_cmd.block_d[7:0] : q_cmd.block_d[15:8];

    always_comb
    begin
        case (idx_reg)
            2'd0:    rt_byte = q_cmd.block_c[15:8];
            2'd1:    rt_byte = q_cmd.block_c[7:0];
            2'd2:    rt_byte = q_cmd.block_d[15:8];
            default: rt_byte = q_cmd.block_d[7:0];
        endcase
    end

    always_comb
    begin
        case (q_cmd.kind)
            rdsgd_pkg::KIND_PS:
            begin
                r_target = rdsgd_pkg::TGT_PS;
                r_pos    = {3'b000, q_cmd.segment[1:0], idx_reg[0]};
                r_char   = d_byte[6:0];
                r_last   = idx_reg[0];
            end
            rdsgd_pkg::KIND_RT_A:
            begin
                r_target = rdsgd_pkg::TGT_RT;
                r_pos    = {q_cmd.segment, idx_reg};
                r_char   = rdsgd_pkg::conv_text(rt_byte);
                r_last   = (idx_reg == 2'd3);
            end
            rdsgd_pkg::KIND_RT_B:
            begin
                r_target = rdsgd_pkg::TGT_RT;
                r_pos    = {1'b0, q_cmd.segment, idx_reg[0]};
                r_char   = rdsgd_pkg::conv_text(d_byte);
                r_last   = idx_reg[0];
            end
            default:
            begin
                r_target = rdsgd_pkg::TGT_NONE;
                r_pos    = 6'd0;
                r_char   = 7'd0;
                r_last   = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = r_last ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prog_id_reg   <= q_cmd.prog_id;
            prog_type_reg <= q_cmd.prog_type;
            tp_reg        <= q_cmd.traffic_program;
            ta_reg        <= q_cmd.traffic_announce;
            ms_reg        <= q_cmd.music_speech;
            di_reg        <= q_cmd.decoder_info;
            target_reg    <= r_target;
            pos_reg       <= r_pos;
            char_reg      <= r_char;
            last_reg      <= r_last;
        end
    end

    assign out_valid        = valid_reg;
    assign prog_id          = prog_id_reg;
    assign prog_type        = prog_type_reg;
    assign traffic_program  = tp_reg;
    assign traffic_announce = ta_reg;
    assign music_speech     = ms_reg;
    assign decoder_info     = di_reg;
    assign write_target     = target_reg;
    assign char_position    = pos_reg;
    assign char_value       = char_reg;
    assign last             = last_reg;

endmodule

// File: design/rds_group_decoder.sv
// rds_group_decoder: top level of the rds group decoder
// depends on rdsgd_pkg, rdsgd_front, rdsgd_queue and rdsgd_back
//
// one input word is a whole rds group (blocks a to d); each group gives one or
// more result words on the output stream, the group's final word flagged by tlast
// group 0 gives two station-name words, group 2a four radiotext words, group 2b
// two, every other group one word with tuser at "no write"
// the front accepts a group in any cycle the command queue has room, updates
// the stored TA, MS and DI bits on a group 0 and queues the group; the back
// walks the queued group and emits one word per cycle into the output
// register while m_tready does not stall it; the first word of a group passes
// through the queue and then the output register
// while m_tready is high the output register takes one word per cycle; a group
// has at most four words, for group 2a; the queue of QUEUE_DEPTH groups lets
// the input run ahead while the output drains
// when m_tready is low the output register holds its word and the queue fills;
// s_tready drops only when the queue is full
// reset clears the stored flags, the queue and the output valid

module rds_group_decoder #(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // block_a, block_b, block_c, block_d
    input  logic [rdsgd_pkg::IN_W-1:0]    s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // prog_id, prog_type, traffic_program, traffic_announce, music_speech,
    // decoder_info, char_position, char_value, zero fill
    output logic [rdsgd_pkg::OUT_W-1:0]   m_tdata,
    // write_target
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);

    rdsgd_pkg::cmd_t push_cmd, pop_cmd;
    logic            q_full, q_push, q_pop, q_valid;

    logic [15:0] prog_id;
    logic [4:0]  prog_type;
    logic        traffic_program, traffic_announce, music_speech;
    logic [3:0]  decoder_info;
    logic [5:0]  char_position;
    logic [6:0]  char_value;

    rdsgd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .block_a  (s_tdata[15:0]),
        .block_b  (s_tdata[31:16]),
        .block_c  (s_tdata[47:32]),
        .block_d  (s_tdata[63:48]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    rdsgd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_cmd   (pop_cmd)
    );

    rdsgd_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_cmd            (pop_cmd),
        .q_pop            (q_pop),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .prog_id          (prog_id),
        .prog_type        (prog_type),
        .traffic_program  (traffic_program),
        .traffic_announce (traffic_announce),
        .music_speech     (music_speech),
        .decoder_info     (decoder_info),
        .write_target     (m_tuser),
        .char_position    (char_position),
        .char_value       (char_value),
        .last             (m_tlast)
    );

    assign m_tdata = {7'd0, char_value, char_position, decoder_info, music_speech,
                      traffic_announce, traffic_program, prog_type, prog_id};

endmodule

// File: tb/sv/tb_rds_group_decoder.sv
// tb_rds_group_decoder: self-checking testbench of the rds group decoder
// depends on rdsgd_pkg and rds_group_decoder; a small scoreboard class predicts
// the result words of each accepted group and checks the output stream against them

`timescale 1ns / 1ps

// one predicted result word, fields as they travel on tdata, tuser and tlast
typedef struct packed {
    logic [15:0] prog_id;
    logic [4:0]  prog_type;
    logic        tp;
    logic        ta;
    logic        ms;
    logic [3:0]  di;
    logic [1:0]  target;
    logic [5:0]  pos;
    logic [6:0]  chr;
    logic        last;
} rds_word_t;

class decoded_word_tracker;
    rds_word_t due_words[$];
    // stored flags as the block should hold them
    logic       ta_state = 1'b0;
    logic       ms_state = 1'b0;
    logic [3:0] di_state = 4'h0;
    int mismatches = 0;
    int words_seen = 0;
    int groups_ps = 0;
    int groups_rt_a = 0;
    int groups_rt_b = 0;
    int groups_other = 0;

    static function logic [6:0] text_char(logic [7:0] raw);
        logic [6:0] low7;
        low7 = raw[6:0];
        if (low7 == rdsgd_pkg::CHR_CR)
            return rdsgd_pkg::CHR_NUL;
        if (low7 == rdsgd_pkg::CHR_LF)
            return rdsgd_pkg::CHR_SPACE;
        return low7;
    endfunction

    function void note_group(logic [63:0] grp);
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
        logic [7:0]  text_bytes [4];
        rds_word_t   w;
        a = grp[15:0];
        b = grp[31:16];
        c = grp[47:32];
        d = grp[63:48];
        text_bytes[0] = c[15:8];
        text_bytes[1] = c[7:0];
        text_bytes[2] = d[15:8];
        text_bytes[3] = d[7:0];
        // group 0 updates the stored flags before any of its words leave
        if (b[15:12] == rdsgd_pkg::GRP_BASIC) begin
            ta_state = b[4];
            ms_state = b[3];
            di_state[b[1:0]] = b[2];
        end
        w = '0;
        w.prog_id = a;
        w.prog_type = b[9:5];
        w.tp = b[10];
        w.ta = ta_state;
        w.ms = ms_state;
        w.di = di_state;
        if (b[15:12] == rdsgd_pkg::GRP_BASIC) begin
            groups_ps++;
            w.target = rdsgd_pkg::TGT_PS;
            // station name passes the low 7 bits with no remap
            for (int k = 0; k < 2; k++) begin
                w.pos = {3'b000, b[1:0], k[0]};
                w.chr = text_bytes[2 + k][6:0];
                w.last = (k == 1);
                due_words.push_back(w);
            end
        end
        else if (b[15:12] == rdsgd_pkg::GRP_TEXT && !b[11]) begin
            groups_rt_a++;
            w.target = rdsgd_pkg::TGT_RT;
            for (int k = 0; k < 4; k++) begin
                w.pos = {b[3:0], k[1:0]};
                w.chr = text_char(text_bytes[k]);
                w.last = (k == 3);
                due_words.push_back(w);
            end
        end
        else if (b[15:12] == rdsgd_pkg::GRP_TEXT) begin
            groups_rt_b++;
            w.target = rdsgd_pkg::TGT_RT;
            for (int k = 0; k < 2; k++) begin
                w.pos = {1'b0, b[3:0], k[0]};
                w.chr = text_char(text_bytes[2 + k]);
                w.last = (k == 1);
                due_words.push_back(w);
            end
        end
        else begin
            groups_other++;
            w.target = rdsgd_pkg::TGT_NONE;
            w.last = 1'b1;
            due_words.push_back(w);
        end
    endfunction

    task report_mismatch(string what);
        $display("mismatch at word %0d: %s", words_seen, what);
        mismatches++;
    endtask

    task check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_word(logic [47:0] data, logic [1:0] user, logic lst);
        rds_word_t want;
        words_seen++;
        if (due_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h user %0d", data, user));
            return;
        end
        want = due_words.pop_front();
        check_field("prog_id", data[15:0], want.prog_id);
        check_field("prog_type", data[20:16], want.prog_type);
        check_field("traffic_program", data[21], want.tp);
        check_field("traffic_announce", data[22], want.ta);
        check_field("music_speech", data[23], want.ms);
        check_field("decoder_info", data[27:24], want.di);
        check_field("char_position", data[33:28], want.pos);
        check_field("char_value", data[40:34], want.chr);
        check_field("zero fill", data[47:41], 0);
        check_field("write_target", user, want.target);
        check_field("last", lst, want.last);
    endtask
endclass

module tb_rds_group_decoder;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 160;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // both sides idle at random while set
    logic idle_on = 1'b1;
    int   cycle_count = 0;

    decoded_word_tracker tracker = new();

    rds_group_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [15:0] block_b_of(logic [3:0] grp, logic ver, logic tp,
                                                logic [4:0] pty, logic [4:0] tail);
        return {grp, ver, tp, pty, tail};
    endfunction

    // random character byte, often a CR or LF with either top bit
    function automatic logic [7:0] pick_char_byte();
        logic [7:0] raw;
        raw = 8'($urandom);
        if ($urandom_range(0, 3) == 0)
            raw[6:0] = ($urandom_range(0, 1) == 0) ? rdsgd_pkg::CHR_CR : rdsgd_pkg::CHR_LF;
        return raw;
    endfunction

    task automatic send_group(input logic [15:0] a, input logic [15:0] b,
                              input logic [15:0] c, input logic [15:0] d);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= {d, c, b, a};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        tracker.note_group({d, c, b, a});
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (tracker.due_words.size() != 0) @(posedge clk);
    endtask

    // output side: random stall before each word, then check it on accept
    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            tracker.check_word(m_tdata, m_tuser, m_tlast);
        end
    end

    initial
    begin
        logic [15:0] b;
        logic [3:0]  grp;
        int          grp_sel;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // station name: every segment, DI set in each then cleared in two, no remap of CR/LF
        send_group(16'h0000, block_b_of(4'd0, 1'b0, 1'b0, 5'd0, 5'b11100), 16'h1234, 16'h0D0A);
        send_group(16'hFFFF, block_b_of(4'd0, 1'b0, 1'b1, 5'd31, 5'b00101), 16'h0000, 16'hFFFF);
        send_group(16'h5A5A, block_b_of(4'd0, 1'b1, 1'b0, 5'd7, 5'b01110), 16'hFFFF, 16'h8D8A);
        send_group(16'hA5A5, block_b_of(4'd0, 1'b1, 1'b1, 5'd16, 5'b10111), 16'h0000, 16'h4142);
        send_group(16'h1111, block_b_of(4'd0, 1'b0, 1'b0, 5'd1, 5'b10000), 16'h0000, 16'h2020);
        send_group(16'h2222, block_b_of(4'd0, 1'b0, 1'b1, 5'd2, 5'b00011), 16'h0000, 16'h7F80);
        send_group(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_group(16'h3333, 16'h0FFF, 16'hFFFF, 16'hFFFF);
        // radiotext 2A: CR/LF remap with and without bit 7, lowest and highest segment
        send_group(16'h4444, block_b_of(4'd2, 1'b0, 1'b0, 5'd0, 5'd0), 16'h0D0A, 16'h8D8A);
        send_group(16'hFFFF, block_b_of(4'd2, 1'b0, 1'b1, 5'd31, 5'd15), 16'hFFFF, 16'h0000);
        send_group(16'h5555, block_b_of(4'd2, 1'b0, 1'b0, 5'd9, 5'd7), 16'h2041, 16'h7F80);
        // radiotext 2B: block c ignored
        send_group(16'h6666, block_b_of(4'd2, 1'b1, 1'b0, 5'd3, 5'd0), 16'hFFFF, 16'h0D0A);
        send_group(16'h7777, block_b_of(4'd2, 1'b1, 1'b1, 5'd31, 5'd15), 16'h0D0A, 16'h8A8D);
        send_group(16'h8888, 16'h2FFF, 16'h0000, 16'h0D0D);
        // other groups leave the flags alone; one more group 0 follows them
        send_group(16'h9999, block_b_of(4'd1, 1'b0, 1'b1, 5'd5, 5'b11111), 16'hFFFF, 16'hFFFF);
        send_group(16'hAAAA, block_b_of(4'd3, 1'b1, 1'b0, 5'd10, 5'b10101), 16'h0D0A, 16'h0D0A);
        send_group(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_group(16'h0000, 16'h4000, 16'h0000, 16'h0000);
        send_group(16'hBBBB, block_b_of(4'd8, 1'b0, 1'b0, 5'd20, 5'b01010), 16'h1357, 16'h2468);
        send_group(16'hCCCC, block_b_of(4'd0, 1'b1, 1'b0, 5'd12, 5'b00110), 16'h0000, 16'h0D0A);
        wait_for_drain();

        // random groups: idling, then a stretch with none, then idling again
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_on = (phase != 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                grp_sel = $urandom_range(0, 99);
                if (grp_sel < 35)
                    grp = rdsgd_pkg::GRP_BASIC;
                else if (grp_sel < 70)
                    grp = rdsgd_pkg::GRP_TEXT;
                else
                    grp = 4'($urandom_range(0, 15));
                b = 16'($urandom);
                b[15:12] = grp;
                send_group(16'($urandom), b, {pick_char_byte(), pick_char_byte()},
                           {pick_char_byte(), pick_char_byte()});
            end
            wait_for_drain();
        end
        idle_on = 1'b1;

        // keep the clock running so that any stray word is caught
        repeat (10) @(posedge clk);
        $display("covered %0d groups: %0d station name, %0d radiotext 2A, %0d 2B, %0d other",
                 tracker.groups_ps + tracker.groups_rt_a + tracker.groups_rt_b
                 + tracker.groups_other, tracker.groups_ps, tracker.groups_rt_a,
                 tracker.groups_rt_b, tracker.groups_other);
        $display("%0d result words checked, %0d mismatches, %0d cycles",
                 tracker.words_seen, tracker.mismatches, cycle_count);
        if (tracker.mismatches == 0 && tracker.due_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
